// ===== rtl/xeu_pkg.sv =====
`default_nettype none

package xeu_pkg;

  localparam int unsigned MAX_LOOKAHEAD_DEF = 16;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned QUEUE_AW          = $clog2(QUEUE_DEPTH);

  localparam int unsigned CP_W  = 21;
  localparam int unsigned ACC_W = CP_W + 4;

  localparam logic [CP_W-1:0]  CP_2B    = 21'h000080;
  localparam logic [CP_W-1:0]  CP_3B    = 21'h000800;
  localparam logic [CP_W-1:0]  CP_4B    = 21'h010000;
  localparam logic [ACC_W-1:0] CP_LIMIT = 25'h0110000;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_G = 8'h67;
  localparam logic [7:0] CH_LO_L = 8'h6C;
  localparam logic [7:0] CH_LO_M = 8'h6D;
  localparam logic [7:0] CH_LO_O = 8'h6F;
  localparam logic [7:0] CH_LO_P = 8'h70;
  localparam logic [7:0] CH_LO_Q = 8'h71;
  localparam logic [7:0] CH_LO_S = 8'h73;
  localparam logic [7:0] CH_LO_T = 8'h74;
  localparam logic [7:0] CH_LO_U = 8'h75;
  localparam logic [7:0] CH_LO_X = 8'h78;
  localparam logic [7:0] CH_UP_X = 8'h58;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       span_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       span_end;
    logic       amp;
    logic       semi;
    logic       dec_ok;
    logic       hex_ok;
    logic       xch;
    logic [3:0] dval;
  } tok_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_UTF,
    ST_LIT,
    ST_REP
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/xeu_front.sv =====
`default_nettype none

module xeu_front (
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire xeu_pkg::in_req_t in_req_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output xeu_pkg::tok_t         tok_o
);
  import xeu_pkg::*;

  logic [7:0] b;

  assign b          = in_req_i.in_byte;
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    tok_o          = '0;
    tok_o.data     = b;
    tok_o.span_end = in_req_i.span_end;
    tok_o.amp      = (b == CH_AMP);
    tok_o.semi     = (b == CH_SEMI);
    tok_o.dec_ok   = b inside {[8'h30:8'h39]};
    tok_o.hex_ok   = b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    tok_o.xch      = (b == CH_LO_X) || (b == CH_UP_X);
    tok_o.dval     = tok_o.dec_ok ? b[3:0] : b[3:0] + 4'd9;
  end

endmodule

`default_nettype wire

// ===== rtl/xeu_fifo.sv =====
`default_nettype none

module xeu_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire xeu_pkg::tok_t push_tok_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output xeu_pkg::tok_t      head_o
);
  import xeu_pkg::*;

  localparam logic [QUEUE_AW-1:0] LAST_PTR = QUEUE_AW'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_AW:0]   FULL_CNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  tok_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;
  logic                do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rp_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = push_i ? ((wp_q == LAST_PTR) ? '0 : wp_q + 1'b1) : wp_q;
    rp_d  = do_pop ? ((rp_q == LAST_PTR) ? '0 : rp_q + 1'b1) : rp_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_tok_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/xeu_back.sv =====
`default_nettype none

module xeu_back #(
  parameter int unsigned MAX_LOOKAHEAD = xeu_pkg::MAX_LOOKAHEAD_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          tok_valid_i,
  input  wire xeu_pkg::tok_t tok_i,
  output logic               tok_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output xeu_pkg::out_req_t  out_req_o
);
  import xeu_pkg::*;

  localparam int unsigned IW     = $clog2(MAX_LOOKAHEAD);
  localparam int unsigned PD     = MAX_LOOKAHEAD - 1;
  localparam logic [IW-1:0] PD_IDX = IW'(PD);

  back_state_e      st_q, st_d;
  logic             in_ent_q, in_ent_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    rd_q, rd_d;
  logic [IW-1:0]    rep_end_q, rep_end_d;
  logic             rep_se_q, rep_se_d;
  logic [1:0]       k_q, k_d, nm1_q, nm1_d;

  tok_t             buf_q [MAX_LOOKAHEAD];
  logic [7:0]       head_q [4];

  logic [CP_W-1:0]  cp_q, cp_d;
  logic             big_q, big_d, bad_q, bad_d, hex_q, hex_d;

  logic [7:0]       hold_q;
  logic             hold_v_q, hold_fin_q;
  out_req_t         out_q;
  logic             out_v_q;

  tok_t             rd_tok, cur_tok;
  logic             cur_e;
  logic             want, done, wr_en, buffering, ent_start, fin_step;
  logic [7:0]       pbyte;
  logic             avail, go, out_free, can_prod, ship;

  logic             is_lt, is_gt, is_amp, is_quot, is_apos, is_num;
  logic [1:0]       nm_new;
  logic [ACC_W-1:0] acc_hex, acc_dec, acc;
  logic             dig_ok;

  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [1:0] nm1,
                                           input logic [1:0] k);
    logic [1:0] sh;
    logic [7:0] r;
    sh = nm1 - k;
    r  = '0;
    if (k == 2'd0) begin
      case (nm1)
        2'd0:    r = {1'b0, cp[6:0]};
        2'd1:    r = {3'b110, cp[10:6]};
        2'd2:    r = {4'b1110, cp[15:12]};
        default: r = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (sh)
        2'd0:    r = {2'b10, cp[5:0]};
        2'd1:    r = {2'b10, cp[11:6]};
        default: r = {2'b10, cp[17:12]};
      endcase
    end
    return r;
  endfunction

  assign rd_tok  = buf_q[rd_q];
  assign cur_tok = (st_q == ST_REP) ? rd_tok : tok_i;
  assign cur_e   = (st_q == ST_REP) ? (rep_se_q && (rd_q == rep_end_q)) : tok_i.span_end;

  assign is_lt   = (cnt_q == IW'(2)) && (head_q[0] == CH_LO_L) && (head_q[1] == CH_LO_T);
  assign is_gt   = (cnt_q == IW'(2)) && (head_q[0] == CH_LO_G) && (head_q[1] == CH_LO_T);
  assign is_amp  = (cnt_q == IW'(3)) && (head_q[0] == CH_LO_A) && (head_q[1] == CH_LO_M)
                   && (head_q[2] == CH_LO_P);
  assign is_quot = (cnt_q == IW'(4)) && (head_q[0] == CH_LO_Q) && (head_q[1] == CH_LO_U)
                   && (head_q[2] == CH_LO_O) && (head_q[3] == CH_LO_T);
  assign is_apos = (cnt_q == IW'(4)) && (head_q[0] == CH_LO_A) && (head_q[1] == CH_LO_P)
                   && (head_q[2] == CH_LO_O) && (head_q[3] == CH_LO_S);
  assign is_num  = (cnt_q >= IW'(2)) && (head_q[0] == CH_HASH);

  assign nm_new  = (cp_q < CP_2B) ? 2'd0 :
                   (cp_q < CP_3B) ? 2'd1 :
                   (cp_q < CP_4B) ? 2'd2 : 2'd3;

  assign acc_hex = {cp_q, cur_tok.dval};
  assign acc_dec = ({4'b0, cp_q} << 3) + ({4'b0, cp_q} << 1) + ACC_W'(cur_tok.dval);
  assign acc     = hex_q ? acc_hex : acc_dec;
  assign dig_ok  = hex_q ? cur_tok.hex_ok : cur_tok.dec_ok;

  always_comb begin
    st_d      = st_q;
    in_ent_d  = in_ent_q;
    cnt_d     = cnt_q;
    rd_d      = rd_q;
    rep_end_d = rep_end_q;
    rep_se_d  = rep_se_q;
    k_d       = k_q;
    nm1_d     = nm1_q;
    want      = 1'b0;
    pbyte     = '0;
    done      = 1'b0;
    wr_en     = 1'b0;
    buffering = 1'b0;
    ent_start = 1'b0;
    fin_step  = 1'b0;
    case (st_q)
      ST_RUN, ST_REP: begin
        if (!in_ent_q) begin
          if (cur_tok.amp && !cur_e) begin
            in_ent_d  = 1'b1;
            cnt_d     = '0;
            ent_start = 1'b1;
          end else begin
            want  = 1'b1;
            pbyte = cur_tok.data;
          end
          fin_step = 1'b1;
        end else if (cur_tok.semi && (st_q == ST_RUN)) begin
          in_ent_d = 1'b0;
          if (is_lt || is_gt || is_amp || is_quot || is_apos) begin
            want  = 1'b1;
            pbyte = is_lt ? CH_LT : is_gt ? CH_GT : is_amp ? CH_AMP :
                    is_quot ? CH_QUOT : CH_APOS;
            cnt_d = '0;
            done  = 1'b1;
          end else if (is_num) begin
            cnt_d = '0;
            if (big_q) begin
              done = 1'b1;
            end else begin
              want  = 1'b1;
              pbyte = utf8_byte(cp_q, nm_new, 2'd0);
              if (nm_new == 2'd0) begin
                done = 1'b1;
              end else begin
                st_d  = ST_UTF;
                k_d   = 2'd1;
                nm1_d = nm_new;
              end
            end
          end else begin
            want  = 1'b1;
            pbyte = CH_AMP;
            rd_d  = '0;
            st_d  = ST_LIT;
          end
        end else if ((cnt_q == PD_IDX) || cur_e) begin
          want      = 1'b1;
          pbyte     = CH_AMP;
          wr_en     = 1'b1;
          rep_end_d = cnt_q;
          rep_se_d  = cur_e;
          rd_d      = '0;
          in_ent_d  = 1'b0;
          cnt_d     = '0;
          st_d      = ST_REP;
        end else begin
          wr_en     = 1'b1;
          buffering = 1'b1;
          cnt_d     = cnt_q + 1'b1;
          fin_step  = 1'b1;
        end
        if (fin_step) begin
          if (st_q == ST_RUN) begin
            done = 1'b1;
          end else if (rd_q == rep_end_q) begin
            done = 1'b1;
            st_d = ST_RUN;
          end else begin
            rd_d = rd_q + 1'b1;
          end
        end
      end
      ST_UTF: begin
        want  = 1'b1;
        pbyte = utf8_byte(cp_q, nm1_q, k_q);
        if (k_q == nm1_q) begin
          done = 1'b1;
          st_d = ST_RUN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_LIT: begin
        want = 1'b1;
        if (rd_q == cnt_q) begin
          pbyte = CH_SEMI;
          cnt_d = '0;
          done  = 1'b1;
          st_d  = ST_RUN;
        end else begin
          pbyte = rd_tok.data;
          rd_d  = rd_q + 1'b1;
        end
      end
      default: begin
        st_d = ST_RUN;
      end
    endcase
  end

  always_comb begin
    cp_d  = cp_q;
    big_d = big_q;
    bad_d = bad_q;
    hex_d = hex_q;
    if (ent_start) begin
      cp_d  = '0;
      big_d = 1'b0;
      bad_d = 1'b0;
      hex_d = 1'b0;
    end else if (buffering && (cnt_q != '0)) begin
      if ((cnt_q == IW'(1)) && cur_tok.xch) begin
        hex_d = 1'b1;
      end else if (!bad_q) begin
        if (!dig_ok) begin
          bad_d = 1'b1;
          big_d = 1'b0;
          cp_d  = '0;
        end else if (!big_q) begin
          if (acc >= CP_LIMIT) begin
            big_d = 1'b1;
          end else begin
            cp_d = acc[CP_W-1:0];
          end
        end
      end
    end
  end

  assign avail     = (st_q == ST_RUN) ? tok_valid_i : 1'b1;
  assign out_free  = !out_v_q || out_ready_i;
  assign can_prod  = !hold_v_q || out_free;
  assign go        = avail && (!want || can_prod);
  assign ship      = hold_v_q && out_free && (hold_fin_q || (go && want));
  assign tok_pop_o = go && (st_q == ST_RUN);

  assign out_valid_o = out_v_q;
  assign out_req_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_RUN;
      in_ent_q   <= 1'b0;
      cnt_q      <= '0;
      rd_q       <= '0;
      rep_end_q  <= '0;
      rep_se_q   <= 1'b0;
      k_q        <= '0;
      nm1_q      <= '0;
      hold_v_q   <= 1'b0;
      hold_fin_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (go) begin
        st_q      <= st_d;
        in_ent_q  <= in_ent_d;
        cnt_q     <= cnt_d;
        rd_q      <= rd_d;
        rep_end_q <= rep_end_d;
        rep_se_q  <= rep_se_d;
        k_q       <= k_d;
        nm1_q     <= nm1_d;
      end
      if (go && want) begin
        hold_v_q   <= 1'b1;
        hold_fin_q <= done;
      end else begin
        if (ship) begin
          hold_v_q <= 1'b0;
        end
        if (go && done) begin
          hold_fin_q <= 1'b1;
        end
      end
      if (ship) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && wr_en) begin
      buf_q[cnt_q] <= cur_tok;
      if (cnt_q < IW'(4)) begin
        head_q[cnt_q[1:0]] <= cur_tok.data;
      end
    end
    if (go) begin
      cp_q  <= cp_d;
      big_q <= big_d;
      bad_q <= bad_d;
      hex_q <= hex_d;
    end
    if (go && want) begin
      hold_q <= pbyte;
    end
    if (ship) begin
      out_q.out_byte <= hold_q;
      out_q.last     <= hold_fin_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_rep_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_REP) |-> (rd_q <= rep_end_q))
    else $error("replay read index past replay end");

  a_rep_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_REP) && go && wr_en) |-> (cnt_q < rd_q))
    else $error("replay write overtakes replay read");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PD_IDX)
    else $error("pending count beyond lookahead");

  a_emit_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_UTF) || (st_q == ST_LIT)) |-> !in_ent_q)
    else $error("entity still open while emitting its expansion");
`endif

endmodule

`default_nettype wire

// ===== rtl/xml_entity_unescape_utf8_core.sv =====
`default_nettype none

// XML entity decoder to UTF-8 with valid/ready channels on both sides. A
// request carries one text byte and a span-end flag; each result carries one
// output byte, with last set on the final byte caused by that request. A front
// stage classifies each byte and pushes it into a 4-deep queue; the back end
// pops it and produces at most one output byte per cycle into a hold register
// and an output register, so input keeps flowing while a result waits. In the back
// end, a plain byte is passed on and a byte inside an open reference is stored;
// on the closing semicolon, a named reference yields one byte, a numeric one its
// n-byte UTF-8 sequence, and an unknown name is copied through between an
// ampersand and a semicolon; a flush (lookahead full or span end inside a
// reference) emits an ampersand, then replays each stored byte (up to
// MAX_LOOKAHEAD), and again for a nested flush at span end. The work per request
// is paced by the single output byte per cycle and the one lookahead read port.

module xml_entity_unescape_utf8_core #(
  parameter int unsigned MAX_LOOKAHEAD = xeu_pkg::MAX_LOOKAHEAD_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire xeu_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output xeu_pkg::out_req_t      out_req_o
);
  import xeu_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  tok_t push_tok, head_tok;

  xeu_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .tok_o      (push_tok)
  );

  xeu_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_tok_i (push_tok),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_tok)
  );

  xeu_back #(
    .MAX_LOOKAHEAD (MAX_LOOKAHEAD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (head_tok),
    .tok_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire
